>>> sv/bktkf_pkg.sv
`timescale 1ns / 1ps
package bktkf_pkg;

    localparam int NUM_TRACKS_DEF = 64;
    localparam int MEAS_DIM       = 4;
    localparam int VEL_DIM        = 3;
    localparam int TID_W          = 6;
    localparam int POS_W          = 32;
    localparam int COV_W          = 48;
    localparam int REG_W          = 47;
    localparam int ACC_W          = 52;
    localparam int COORD_W        = 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR      = 2'd2;

    localparam logic [REG_W-1:0] PROCESS_NOISE_RST = 47'd429497;
    localparam logic [REG_W-1:0] MEAS_NOISE_RST    = 47'd42949673;
    localparam logic [REG_W-1:0] INIT_VAR_RST      = 47'd4294967296;

    localparam logic signed [ACC_W-1:0] COV_MAX_X = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] COV_MIN_X = 52'shF_8000_0000_0000;
    localparam logic signed [ACC_W-1:0] POS_MAX_X = 52'sh0_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] POS_MIN_X = 52'shF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_PREDICT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_RD,
        ST_LAT,
        ST_CALC,
        ST_DIVS,
        ST_DIVW,
        ST_MULS,
        ST_MULW,
        ST_WR,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MUL_KP_D,
        MUL_KP_P,
        MUL_KV_D,
        MUL_KP_C,
        MUL_KV_C
    } t_mul_sel;

    typedef enum logic {
        DIV_P,
        DIV_C
    } t_div_sel;

    typedef struct packed {
        logic [1:0]              operation;
        logic [TID_W-1:0]        track_id;
        logic signed [POS_W-1:0] meas_x1;
        logic signed [POS_W-1:0] meas_y1;
        logic signed [POS_W-1:0] meas_x2;
        logic signed [POS_W-1:0] meas_y2;
    } t_in_item;

    typedef struct packed {
        logic [TID_W-1:0]        out_track;
        logic                    status;
        logic signed [POS_W-1:0] est_x1;
        logic signed [POS_W-1:0] est_y1;
        logic signed [POS_W-1:0] est_x2;
        logic signed [POS_W-1:0] est_y2;
        logic signed [POS_W-1:0] vel_x1;
        logic signed [POS_W-1:0] vel_y1;
        logic signed [POS_W-1:0] vel_x2;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [COV_W-1:0] pvar;
    } t_pos_entry;

    typedef struct packed {
        logic signed [POS_W-1:0] vel;
        logic signed [COV_W-1:0] cvar;
        logic signed [COV_W-1:0] vvar;
    } t_vel_entry;

    typedef struct packed {
        logic               ld_item;
        logic               rd;
        logic               latch;
        logic               calc;
        logic               div_start;
        t_div_sel           div_sel;
        logic               mul_start;
        t_mul_sel           mul_sel;
        logic               wr;
        logic [COORD_W-1:0] coord;
        logic               out_load;
    } t_cmd;

    typedef struct packed {
        logic ok;
        t_op  op;
        logic div_done;
        logic mul_done;
        logic out_busy;
    } t_status;

    function automatic logic signed [ACC_W-1:0] f_sx48(input logic signed [COV_W-1:0] v);
        return {{(ACC_W-COV_W){v[COV_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sx32(input logic signed [POS_W-1:0] v);
        return {{(ACC_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic signed [COV_W-1:0] f_sat48(input logic signed [ACC_W-1:0] v);
        logic signed [COV_W-1:0] r;
        if (v > COV_MAX_X) begin
            r = COV_MAX_X[COV_W-1:0];
        end else if (v < COV_MIN_X) begin
            r = COV_MIN_X[COV_W-1:0];
        end else begin
            r = v[COV_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX_X) begin
            r = POS_MAX_X[POS_W-1:0];
        end else if (v < POS_MIN_X) begin
            r = POS_MIN_X[POS_W-1:0];
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/bktkf_ram.sv
`timescale 1ns / 1ps
module bktkf_ram #(
    parameter int W = 8,
    parameter int D = 4,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bktkf_div.sv
`timescale 1ns / 1ps
module bktkf_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [bktkf_pkg::COV_W-1:0]    i_num,
    input  logic signed [bktkf_pkg::COV_W:0]      i_den,
    output logic                                  o_done,
    output logic signed [bktkf_pkg::COV_W-1:0]    o_quot
);

    localparam int W  = bktkf_pkg::COV_W;
    localparam int QW = W - 1;

    logic [W-1:0]   w_un;
    logic [W:0]     w_ud_full;
    logic [W-1:0]   w_ud;
    logic           w_sat;
    logic           w_neg;
    logic [W:0]     w_rem2;
    logic           w_ge;
    logic [W-1:0]   w_rem_nx;
    logic [QW-1:0]  w_q_nx;

    logic           r_busy;
    logic           r_done;
    logic [5:0]     r_cnt;
    logic [W-1:0]   r_ud;
    logic [W-1:0]   r_rem;
    logic [QW-1:0]  r_sr;
    logic [QW-1:0]  r_q;
    logic           r_neg;
    logic [W-1:0]   r_res;

    always_comb begin
        w_un      = i_num[W-1] ? W'(-i_num) : i_num;
        w_ud_full = i_den[W] ? (W+1)'(-i_den) : i_den;
        w_ud      = w_ud_full[W-1:0];
        w_sat     = {15'b0, w_un} >= {w_ud, 15'b0};
        w_neg     = i_num[W-1] ^ i_den[W];
        w_rem2    = {r_rem, r_sr[QW-1]};
        w_ge      = w_rem2 >= {1'b0, r_ud};
        w_rem_nx  = w_ge ? W'(w_rem2 - {1'b0, r_ud}) : w_rem2[W-1:0];
        w_q_nx    = {r_q[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= w_neg;
                r_ud  <= w_ud;
                if (i_den == '0) begin
                    r_res  <= '0;
                    r_done <= 1'b1;
                end else if (w_sat) begin
                    r_res  <= w_neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {15'b0, w_un[W-1:15]};
                    r_sr   <= {w_un[14:0], 32'b0};
                    r_q    <= '0;
                    r_cnt  <= 6'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_rem_nx;
                r_q   <= w_q_nx;
                r_sr  <= {r_sr[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_neg ? W'(-{1'b0, w_q_nx}) : {1'b0, w_q_nx};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

>>> sv/bktkf_mul.sv
`timescale 1ns / 1ps
module bktkf_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [bktkf_pkg::COV_W-1:0]    i_a,
    input  logic signed [bktkf_pkg::COV_W-1:0]    i_b,
    output logic                                  o_done,
    output logic signed [bktkf_pkg::COV_W-1:0]    o_prod
);

    localparam int W  = bktkf_pkg::COV_W;
    localparam int HW = W / 2;
    localparam int PW = 2 * W;

    logic [W-1:0]  w_ua;
    logic [W-1:0]  w_ub;
    logic [HW-1:0] w_ha;
    logic [HW-1:0] w_hb;
    logic [PW-1:0] w_pp_sh;
    logic [PW-1:0] w_sum;
    logic [63:0]   w_mag;
    logic          w_big;

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_step;
    logic [W-1:0]  r_ua;
    logic [W-1:0]  r_ub;
    logic          r_neg;
    logic [W-1:0]  r_pp;
    logic [1:0]    r_tag;
    logic [PW-1:0] r_acc;
    logic [W-1:0]  r_res;

    always_comb begin
        w_ua = i_a[W-1] ? W'(-i_a) : i_a;
        w_ub = i_b[W-1] ? W'(-i_b) : i_b;
        w_ha = r_step[1] ? r_ua[W-1:HW] : r_ua[HW-1:0];
        w_hb = r_step[0] ? r_ub[W-1:HW] : r_ub[HW-1:0];
        unique case (r_tag)
            2'd0:    w_pp_sh = {{W{1'b0}}, r_pp};
            2'd3:    w_pp_sh = {r_pp, {W{1'b0}}};
            default: w_pp_sh = {{HW{1'b0}}, r_pp, {HW{1'b0}}};
        endcase
        w_sum = r_acc + PW'(64'h8000_0000);
        w_mag = w_sum[PW-1:32];
        w_big = w_mag >= 64'h0000_8000_0000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ua   <= w_ua;
                r_ub   <= w_ub;
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_acc  <= '0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step < 3'd4) begin
                    r_pp  <= w_ha * w_hb;
                    r_tag <= {r_step[1], r_step[0]};
                end
                if (r_step >= 3'd1 && r_step <= 3'd4) begin
                    r_acc <= r_acc + w_pp_sh;
                end
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_neg) begin
                        r_res <= w_big ? {1'b1, {(W-1){1'b0}}} : W'(-w_mag[W-1:0]);
                    end else begin
                        r_res <= w_big ? {1'b0, {(W-1){1'b1}}} : w_mag[W-1:0];
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_res;

endmodule

>>> sv/bktkf_ctrl.sv
`timescale 1ns / 1ps
module bktkf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bktkf_pkg::t_status   i_status,
    output bktkf_pkg::t_cmd      o_cmd
);

    localparam logic [bktkf_pkg::COORD_W-1:0] COORD_LAST =
        bktkf_pkg::COORD_W'(bktkf_pkg::MEAS_DIM - 1);

    bktkf_pkg::t_state   r_state, n_state;
    logic [bktkf_pkg::COORD_W-1:0] r_coord, n_coord;
    bktkf_pkg::t_div_sel r_dsel, n_dsel;
    bktkf_pkg::t_mul_sel r_msel, n_msel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bktkf_pkg::ST_IDLE;
            r_coord <= '0;
            r_dsel  <= bktkf_pkg::DIV_P;
            r_msel  <= bktkf_pkg::MUL_KP_D;
        end else begin
            r_state <= n_state;
            r_coord <= n_coord;
            r_dsel  <= n_dsel;
            r_msel  <= n_msel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_coord = r_coord;
        n_dsel  = r_dsel;
        n_msel  = r_msel;
        o_cmd   = '0;
        o_cmd.coord   = r_coord;
        o_cmd.div_sel = r_dsel;
        o_cmd.mul_sel = r_msel;
        o_in_stall = (r_state != bktkf_pkg::ST_IDLE);
        unique case (r_state)
            bktkf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = bktkf_pkg::ST_CHK;
                end
            end
            bktkf_pkg::ST_CHK: begin
                n_coord = '0;
                n_state = i_status.ok ? bktkf_pkg::ST_RD : bktkf_pkg::ST_FIN;
            end
            bktkf_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state = bktkf_pkg::ST_LAT;
            end
            bktkf_pkg::ST_LAT: begin
                o_cmd.latch = 1'b1;
                if (i_status.op == bktkf_pkg::OP_UPDATE) begin
                    n_dsel  = bktkf_pkg::DIV_P;
                    n_state = bktkf_pkg::ST_DIVS;
                end else begin
                    n_state = bktkf_pkg::ST_CALC;
                end
            end
            bktkf_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = bktkf_pkg::ST_WR;
            end
            bktkf_pkg::ST_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = bktkf_pkg::ST_DIVW;
            end
            bktkf_pkg::ST_DIVW: begin
                if (i_status.div_done) begin
                    if (r_dsel == bktkf_pkg::DIV_P && r_coord != COORD_LAST) begin
                        n_dsel  = bktkf_pkg::DIV_C;
                        n_state = bktkf_pkg::ST_DIVS;
                    end else begin
                        n_msel  = bktkf_pkg::MUL_KP_D;
                        n_state = bktkf_pkg::ST_MULS;
                    end
                end
            end
            bktkf_pkg::ST_MULS: begin
                o_cmd.mul_start = 1'b1;
                n_state = bktkf_pkg::ST_MULW;
            end
            bktkf_pkg::ST_MULW: begin
                if (i_status.mul_done) begin
                    n_state = bktkf_pkg::ST_MULS;
                    unique case (r_msel)
                        bktkf_pkg::MUL_KP_D: n_msel = bktkf_pkg::MUL_KP_P;
                        bktkf_pkg::MUL_KP_P: begin
                            // last coordinate has no velocity terms
                            if (r_coord == COORD_LAST) begin
                                n_state = bktkf_pkg::ST_WR;
                            end else begin
                                n_msel = bktkf_pkg::MUL_KV_D;
                            end
                        end
                        bktkf_pkg::MUL_KV_D: n_msel = bktkf_pkg::MUL_KP_C;
                        bktkf_pkg::MUL_KP_C: n_msel = bktkf_pkg::MUL_KV_C;
                        default:             n_state = bktkf_pkg::ST_WR;
                    endcase
                end
            end
            bktkf_pkg::ST_WR: begin
                o_cmd.wr = 1'b1;
                if (r_coord == COORD_LAST) begin
                    n_state = bktkf_pkg::ST_FIN;
                end else begin
                    n_coord = r_coord + 1'b1;
                    n_state = bktkf_pkg::ST_RD;
                end
            end
            bktkf_pkg::ST_FIN: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = bktkf_pkg::ST_IDLE;
                end
            end
            default: n_state = bktkf_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> sv/bktkf_dp.sv
`timescale 1ns / 1ps
module bktkf_dp #(
    parameter int NUM_TRACKS = bktkf_pkg::NUM_TRACKS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bktkf_pkg::t_cmd                        i_cmd,
    output bktkf_pkg::t_status                     o_status,
    input  bktkf_pkg::t_in_item                    i_in_data,
    input  logic                                   i_cfg_valid,
    input  logic [bktkf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bktkf_pkg::REG_W-1:0]            i_cfg_data,
    output logic                                   o_out_valid,
    output bktkf_pkg::t_out_item                   o_out_data,
    input  logic                                   i_out_stall
);

    localparam int PW  = bktkf_pkg::POS_W;
    localparam int CW  = bktkf_pkg::COV_W;
    localparam int TU  = (NUM_TRACKS < 64) ? NUM_TRACKS : 64;
    localparam int PD  = TU * bktkf_pkg::MEAS_DIM;
    localparam int VD  = TU * bktkf_pkg::VEL_DIM;
    localparam int PA_W = (PD > 1) ? $clog2(PD) : 1;
    localparam int VA_W = (VD > 1) ? $clog2(VD) : 1;
    localparam int VI_W = (TU > 1) ? $clog2(TU) : 1;
    localparam int PE_W = $bits(bktkf_pkg::t_pos_entry);
    localparam int VE_W = $bits(bktkf_pkg::t_vel_entry);
    localparam logic [bktkf_pkg::COORD_W-1:0] VEL_LIM =
        bktkf_pkg::COORD_W'(bktkf_pkg::VEL_DIM);

    bktkf_pkg::t_in_item   r_item;
    bktkf_pkg::t_op        w_op;
    logic [bktkf_pkg::REG_W-1:0] r_q, r_r, r_iv;
    logic [TU-1:0]         r_valid;
    logic                  w_inrange;
    logic                  w_ok;
    logic [VI_W-1:0]       w_vidx;

    logic [PA_W-1:0]       w_pos_addr;
    logic [8:0]            w_vel_lin;
    logic [VA_W-1:0]       w_vel_addr;
    logic [PE_W-1:0]       w_pos_rdata;
    logic [VE_W-1:0]       w_vel_rdata;
    bktkf_pkg::t_pos_entry w_pos_rd, w_pos_wr;
    bktkf_pkg::t_vel_entry w_vel_rd, w_vel_wr;
    logic                  w_has_vel;
    logic                  w_pos_we, w_vel_we;

    logic signed [PW-1:0]  w_meas;
    logic signed [PW-1:0]  r_pos, r_vel, r_npos, r_nvel;
    logic signed [CW-1:0]  r_p, r_c, r_v, r_np, r_nc, r_nv;
    logic signed [CW-1:0]  r_kp, r_kv;
    logic signed [PW:0]    r_d;
    logic signed [CW:0]    r_s;
    logic signed [PW-1:0]  r_res_pos [bktkf_pkg::MEAS_DIM];
    logic signed [PW-1:0]  r_res_vel [bktkf_pkg::VEL_DIM];

    logic signed [CW-1:0]  w_div_num;
    logic                  w_div_done;
    logic signed [CW-1:0]  w_div_q;
    logic signed [CW-1:0]  w_mul_a, w_mul_b;
    logic                  w_mul_done;
    logic signed [CW-1:0]  w_mul_p;

    logic                  r_out_valid;
    bktkf_pkg::t_out_item  r_out;

    assign w_op      = bktkf_pkg::t_op'(r_item.operation);
    assign w_inrange = int'(r_item.track_id) < NUM_TRACKS;
    assign w_vidx    = r_item.track_id[VI_W-1:0];
    assign w_ok      = w_inrange && (w_op == bktkf_pkg::OP_INIT || r_valid[w_vidx]);
    assign w_has_vel = i_cmd.coord < VEL_LIM;

    assign o_status.ok       = w_ok;
    assign o_status.op       = w_op;
    assign o_status.div_done = w_div_done;
    assign o_status.mul_done = w_mul_done;
    assign o_status.out_busy = r_out_valid && i_out_stall;

    // track*4+coord and track*3+coord
    assign w_pos_addr = PA_W'({r_item.track_id, i_cmd.coord});
    assign w_vel_lin  = {3'b0, r_item.track_id} + {2'b0, r_item.track_id, 1'b0}
                      + {7'b0, i_cmd.coord};
    assign w_vel_addr = VA_W'(w_vel_lin);

    assign w_pos_rd = bktkf_pkg::t_pos_entry'(w_pos_rdata);
    assign w_vel_rd = bktkf_pkg::t_vel_entry'(w_vel_rdata);
    assign w_pos_wr = '{pos: r_npos, pvar: r_np};
    assign w_vel_wr = '{vel: r_nvel, cvar: r_nc, vvar: r_nv};
    assign w_pos_we = i_cmd.wr && w_op != bktkf_pkg::OP_NONE;
    assign w_vel_we = w_pos_we && w_has_vel;

    always_comb begin
        unique case (i_cmd.coord)
            2'd0:    w_meas = r_item.meas_x1;
            2'd1:    w_meas = r_item.meas_y1;
            2'd2:    w_meas = r_item.meas_x2;
            default: w_meas = r_item.meas_y2;
        endcase
        w_div_num = (i_cmd.div_sel == bktkf_pkg::DIV_P) ? r_p : r_c;
        unique case (i_cmd.mul_sel)
            bktkf_pkg::MUL_KP_D: begin w_mul_a = r_kp; w_mul_b = {{(CW-PW-1){r_d[PW]}}, r_d}; end
            bktkf_pkg::MUL_KP_P: begin w_mul_a = r_kp; w_mul_b = r_p; end
            bktkf_pkg::MUL_KV_D: begin w_mul_a = r_kv; w_mul_b = {{(CW-PW-1){r_d[PW]}}, r_d}; end
            bktkf_pkg::MUL_KP_C: begin w_mul_a = r_kp; w_mul_b = r_c; end
            default:             begin w_mul_a = r_kv; w_mul_b = r_c; end
        endcase
    end

    bktkf_ram #(.W(PE_W), .D(PD)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_addr),
        .i_wdata (w_pos_wr),
        .i_re    (i_cmd.rd),
        .i_raddr (w_pos_addr),
        .o_rdata (w_pos_rdata)
    );

    bktkf_ram #(.W(VE_W), .D(VD)) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (w_vel_we),
        .i_waddr (w_vel_addr),
        .i_wdata (w_vel_wr),
        .i_re    (i_cmd.rd && w_has_vel),
        .i_raddr (w_vel_addr),
        .o_rdata (w_vel_rdata)
    );

    bktkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    bktkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= bktkf_pkg::PROCESS_NOISE_RST;
            r_r         <= bktkf_pkg::MEAS_NOISE_RST;
            r_iv        <= bktkf_pkg::INIT_VAR_RST;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bktkf_pkg::CFG_PROCESS_NOISE: r_q  <= i_cfg_data;
                    bktkf_pkg::CFG_MEAS_NOISE:    r_r  <= i_cfg_data;
                    bktkf_pkg::CFG_INIT_VAR:      r_iv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.wr && w_op == bktkf_pkg::OP_INIT) begin
                r_valid[w_vidx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.latch) begin
            r_pos  <= w_pos_rd.pos;
            r_p    <= w_pos_rd.pvar;
            r_vel  <= w_vel_rd.vel;
            r_c    <= w_vel_rd.cvar;
            r_v    <= w_vel_rd.vvar;
            r_npos <= w_pos_rd.pos;
            r_np   <= w_pos_rd.pvar;
            r_nvel <= w_vel_rd.vel;
            r_nc   <= w_vel_rd.cvar;
            r_nv   <= w_vel_rd.vvar;
            r_d    <= {w_meas[PW-1], w_meas} - {w_pos_rd.pos[PW-1], w_pos_rd.pos};
            r_s    <= {w_pos_rd.pvar[CW-1], w_pos_rd.pvar} + {2'b0, r_r};
        end
        if (i_cmd.calc) begin
            unique case (w_op)
                bktkf_pkg::OP_INIT: begin
                    r_npos <= w_meas;
                    r_np   <= {1'b0, r_iv};
                    r_nvel <= '0;
                    r_nc   <= '0;
                    r_nv   <= {1'b0, r_iv};
                end
                bktkf_pkg::OP_PREDICT: begin
                    if (w_has_vel) begin
                        r_npos <= bktkf_pkg::f_sat32(bktkf_pkg::f_sx32(r_pos)
                                                     + bktkf_pkg::f_sx32(r_vel));
                        r_np   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_p)
                                                     + bktkf_pkg::f_sx48(r_c)
                                                     + bktkf_pkg::f_sx48(r_c)
                                                     + bktkf_pkg::f_sx48(r_v)
                                                     + {5'b0, r_q});
                        r_nc   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_c)
                                                     + bktkf_pkg::f_sx48(r_v));
                        r_nv   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_v) + {5'b0, r_q});
                    end else begin
                        r_np   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_p) + {5'b0, r_q});
                    end
                end
                default: ;
            endcase
        end
        if (w_div_done) begin
            if (i_cmd.div_sel == bktkf_pkg::DIV_P) begin
                r_kp <= w_div_q;
            end else begin
                r_kv <= w_div_q;
            end
        end
        if (w_mul_done) begin
            unique case (i_cmd.mul_sel)
                bktkf_pkg::MUL_KP_D: r_npos <= bktkf_pkg::f_sat32(bktkf_pkg::f_sx32(r_pos)
                                                                 + bktkf_pkg::f_sx48(w_mul_p));
                bktkf_pkg::MUL_KP_P: r_np   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_p)
                                                                 - bktkf_pkg::f_sx48(w_mul_p));
                bktkf_pkg::MUL_KV_D: r_nvel <= bktkf_pkg::f_sat32(bktkf_pkg::f_sx32(r_vel)
                                                                 + bktkf_pkg::f_sx48(w_mul_p));
                bktkf_pkg::MUL_KP_C: r_nc   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_c)
                                                                 - bktkf_pkg::f_sx48(w_mul_p));
                default:             r_nv   <= bktkf_pkg::f_sat48(bktkf_pkg::f_sx48(r_v)
                                                                 - bktkf_pkg::f_sx48(w_mul_p));
            endcase
        end
        if (i_cmd.wr) begin
            r_res_pos[i_cmd.coord] <= r_npos;
            if (w_has_vel) begin
                r_res_vel[i_cmd.coord] <= r_nvel;
            end
        end
        if (i_cmd.out_load) begin
            r_out.out_track <= r_item.track_id;
            r_out.status    <= !w_ok;
            r_out.est_x1    <= w_ok ? r_res_pos[0] : '0;
            r_out.est_y1    <= w_ok ? r_res_pos[1] : '0;
            r_out.est_x2    <= w_ok ? r_res_pos[2] : '0;
            r_out.est_y2    <= w_ok ? r_res_pos[3] : '0;
            r_out.vel_x1    <= w_ok ? r_res_vel[0] : '0;
            r_out.vel_y1    <= w_ok ? r_res_vel[1] : '0;
            r_out.vel_x2    <= w_ok ? r_res_vel[2] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/box_tracker_kalman_filter_unit.sv
`timescale 1ns / 1ps
// Track table Kalman filter: each input beat initialises, predicts, updates or just reads one
// track (four box coordinates, three velocities, each pair its own 2x2 filter) and
// returns one result beat with the new estimate, or status 1 when the track is not
// initialised or out of range. One item is processed at a time, coordinate by
// coordinate through a registered-read track memory. Update time is set mostly by
// the one-bit-per-cycle gain divider (seven divisions) and the multi-cycle 48x48
// multiplier (17 products). A new item is taken while the previous result still
// waits in the output register. Configuration writes are always ready and must
// be made while the block is idle.
module box_tracker_kalman_filter_unit #(
    parameter int NUM_TRACKS = bktkf_pkg::NUM_TRACKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bktkf_pkg::t_in_item               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bktkf_pkg::t_out_item              o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bktkf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bktkf_pkg::REG_W-1:0]       i_cfg_data
);

    bktkf_pkg::t_cmd    w_cmd;
    bktkf_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    bktkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bktkf_dp #(.NUM_TRACKS(NUM_TRACKS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
